[design/cst_pkg.sv]
// shared types, token kinds, character codes and keyword tables for the tokenizer
package cst_pkg;

    typedef enum logic [3:0] {
        M_IDLE    = 4'd0,
        M_MINUS   = 4'd1,
        M_SLASH   = 4'd2,
        M_GT      = 4'd3,
        M_LT      = 4'd4,
        M_SEMI1   = 4'd5,
        M_SEMI2   = 4'd6,
        M_HATP    = 4'd7,
        M_QUESP   = 4'd8,
        M_WORD    = 4'd9,
        M_HATT    = 4'd10,
        M_QUEST   = 4'd11,
        M_NUMBER  = 4'd12,
        M_STRING  = 4'd13,
        M_COMMENT = 4'd14
    } t_mode;

    typedef struct packed {
        logic       is_text;
        logic [7:0] text_char;
        logic [5:0] token_kind;
    } t_result;

    typedef struct packed {
        logic [1:0] cnt;
        t_result    r0;
        t_result    r1;
    } t_step_out;

    localparam int KW_COUNT = 23;
    localparam int KW_POS   = 6;
    localparam logic [KW_COUNT-1:0] KW_ALL = {KW_COUNT{1'b1}};

    localparam logic [5:0] KIND_MINUS_GT = 6'd0;
    localparam logic [5:0] KIND_MINUS    = 6'd1;
    localparam logic [5:0] KIND_SLASH_EQ = 6'd2;
    localparam logic [5:0] KIND_SLASH    = 6'd3;
    localparam logic [5:0] KIND_GT_EQ    = 6'd4;
    localparam logic [5:0] KIND_GT       = 6'd5;
    localparam logic [5:0] KIND_LT_EQ    = 6'd6;
    localparam logic [5:0] KIND_LT       = 6'd7;
    localparam logic [5:0] KIND_PLUS     = 6'd8;
    localparam logic [5:0] KIND_STAR     = 6'd9;
    localparam logic [5:0] KIND_EQ       = 6'd10;
    localparam logic [5:0] KIND_LBRACE   = 6'd11;
    localparam logic [5:0] KIND_RBRACE   = 6'd12;
    localparam logic [5:0] KIND_LBRACKET = 6'd13;
    localparam logic [5:0] KIND_RBRACKET = 6'd14;
    localparam logic [5:0] KIND_LPAREN   = 6'd15;
    localparam logic [5:0] KIND_RPAREN   = 6'd16;
    localparam logic [5:0] KIND_COLON    = 6'd17;
    localparam logic [5:0] KIND_IDENT    = 6'd18;
    localparam logic [5:0] KIND_HAT_NAME = 6'd19;
    localparam logic [5:0] KIND_QUES_NAME = 6'd20;
    localparam logic [5:0] KIND_COMMENT  = 6'd21;
    localparam logic [5:0] KIND_SEMI     = 6'd22;
    localparam logic [5:0] KIND_REAL     = 6'd23;
    localparam logic [5:0] KIND_INTEGER  = 6'd24;
    localparam logic [5:0] KIND_STRING   = 6'd25;
    localparam logic [5:0] KIND_KW_BASE  = 6'd26;

    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_GT       = 8'h3E;
    localparam logic [7:0] CH_LT       = 8'h3C;
    localparam logic [7:0] CH_SLASH    = 8'h2F;
    localparam logic [7:0] CH_EQ       = 8'h3D;
    localparam logic [7:0] CH_PLUS     = 8'h2B;
    localparam logic [7:0] CH_STAR     = 8'h2A;
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_LPAREN   = 8'h28;
    localparam logic [7:0] CH_RPAREN   = 8'h29;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_UNDER    = 8'h5F;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_HAT      = 8'h5E;
    localparam logic [7:0] CH_QUES     = 8'h3F;
    localparam logic [7:0] CH_NEWLINE  = 8'h0A;

    localparam logic [KW_POS*8-1:0] KW_TEXT [KW_COUNT] = '{
        "if", "for", "each", "repeat", "while", "times", "start", "fn",
        "bool", "int", "real", "string", "put", "else", "in", "list",
        "say", "pr", "prn", "true", "false", "input", "call"
    };

    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd2, 3'd3, 3'd4, 3'd6, 3'd5, 3'd5, 3'd5, 3'd2,
        3'd4, 3'd3, 3'd4, 3'd6, 3'd3, 3'd4, 3'd2, 3'd4,
        3'd3, 3'd2, 3'd3, 3'd4, 3'd5, 3'd5, 3'd4
    };

    // character at a position of a keyword, zero past its end
    function automatic logic [7:0] kw_byte(input int idx, input int pos);
        logic [KW_POS*8-1:0] w;
        logic [7:0]          b;
        w = KW_TEXT[idx];
        b = 8'h00;
        if (pos < int'(KW_LEN[idx])) begin
            b = w[(int'(KW_LEN[idx]) - 1 - pos) * 8 +: 8];
        end
        return b;
    endfunction

    function automatic t_result mk_text(input logic [7:0] c);
        t_result r;
        r.is_text    = 1'b1;
        r.text_char  = c;
        r.token_kind = 6'd0;
        return r;
    endfunction

    function automatic t_result mk_kind(input logic [5:0] k);
        t_result r;
        r.is_text    = 1'b0;
        r.text_char  = 8'h00;
        r.token_kind = k;
        return r;
    endfunction

endpackage

[design/cst_kw_match.sv]
// per-position keyword matcher: drops keywords that disagree with the next character
module cst_kw_match
    import cst_pkg::*;
(
    input  logic [KW_COUNT-1:0] i_alive,
    input  logic [2:0]          i_len,
    input  logic [7:0]          i_char,
    output logic [KW_COUNT-1:0] o_alive
);

    always_comb begin
        logic [7:0] expect_ch;
        for (int i = 0; i < KW_COUNT; i++) begin
            expect_ch = 8'h00;
            for (int q = 0; q < KW_POS; q++) begin
                if (i_len == 3'(q)) begin
                    expect_ch = kw_byte(i, q);
                end
            end
            o_alive[i] = i_alive[i] && (i_len < 3'(KW_POS)) && (expect_ch == i_char);
        end
    end

endmodule

[design/cst_step.sv]
// tokenizer state and the per-character decode that forms up to two results
module cst_step
    import cst_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  logic [7:0] i_char,
    input  logic      i_eoi,
    output t_step_out o_res
);

    t_mode               r_mode, n_mode;
    logic [KW_COUNT-1:0] r_alive, n_alive;
    logic [2:0]          r_len, n_len;
    logic                r_dot, n_dot;

    logic [KW_COUNT-1:0] w_start_alive, w_next_alive;
    logic is_alpha, is_digit, is_alnum, is_word;

    t_mode               ic_mode;
    logic                ic_emit;
    t_result             ic_res;
    logic [KW_COUNT-1:0] ic_alive;
    logic [2:0]          ic_len;

    logic                ck_has;
    logic [5:0]          ck_kind;

    cst_kw_match u_kw_start (
        .i_alive (KW_ALL),
        .i_len   (3'd0),
        .i_char  (i_char),
        .o_alive (w_start_alive)
    );

    cst_kw_match u_kw_next (
        .i_alive (r_alive),
        .i_len   (r_len),
        .i_char  (i_char),
        .o_alive (w_next_alive)
    );

    assign is_alpha = ((i_char >= 8'h61) && (i_char <= 8'h7A)) ||
                      ((i_char >= 8'h41) && (i_char <= 8'h5A));
    assign is_digit = (i_char >= 8'h30) && (i_char <= 8'h39);
    assign is_alnum = is_alpha || is_digit;
    assign is_word  = is_alnum || (i_char == CH_UNDER);

    // character seen from the idle state
    always_comb begin
        ic_mode  = M_IDLE;
        ic_emit  = 1'b0;
        ic_res   = mk_kind(KIND_MINUS_GT);
        ic_alive = KW_ALL;
        ic_len   = 3'd0;
        priority if (i_char == CH_MINUS) begin
            ic_mode = M_MINUS;
        end else if (i_char == CH_SLASH) begin
            ic_mode = M_SLASH;
        end else if (i_char == CH_GT) begin
            ic_mode = M_GT;
        end else if (i_char == CH_LT) begin
            ic_mode = M_LT;
        end else if (i_char == CH_PLUS) begin
            ic_emit = 1'b1;
            ic_res  = mk_kind(KIND_PLUS);
        end else if (i_char == CH_STAR) begin
            ic_emit = 1'b1;
            ic_res  = mk_kind(KIND_STAR);
        end else if (i_char == CH_EQ) begin
            ic_emit = 1'b1;
            ic_res  = mk_kind(KIND_EQ);
        end else if (i_char == CH_LBRACE) begin
            ic_emit = 1'b1;
            ic_res  = mk_kind(KIND_LBRACE);
        end else if (i_char == CH_RBRACE) begin
            ic_emit = 1'b1;
            ic_res  = mk_kind(KIND_RBRACE);
        end else if (i_char == CH_LBRACKET) begin
            ic_emit = 1'b1;
            ic_res  = mk_kind(KIND_LBRACKET);
        end else if (i_char == CH_RBRACKET) begin
            ic_emit = 1'b1;
            ic_res  = mk_kind(KIND_RBRACKET);
        end else if (i_char == CH_LPAREN) begin
            ic_emit = 1'b1;
            ic_res  = mk_kind(KIND_LPAREN);
        end else if (i_char == CH_RPAREN) begin
            ic_emit = 1'b1;
            ic_res  = mk_kind(KIND_RPAREN);
        end else if (i_char == CH_COLON) begin
            ic_emit = 1'b1;
            ic_res  = mk_kind(KIND_COLON);
        end else if (i_char == CH_HAT) begin
            ic_mode = M_HATP;
        end else if (i_char == CH_QUES) begin
            ic_mode = M_QUESP;
        end else if (i_char == CH_SEMI) begin
            ic_mode = M_SEMI1;
        end else if (i_char == CH_QUOTE) begin
            ic_mode = M_STRING;
        end else if (is_alpha || (i_char == CH_UNDER)) begin
            ic_mode  = M_WORD;
            ic_emit  = 1'b1;
            ic_res   = mk_text(i_char);
            ic_alive = w_start_alive;
            ic_len   = 3'd1;
        end else if (is_digit) begin
            ic_mode = M_NUMBER;
            ic_emit = 1'b1;
            ic_res  = mk_text(i_char);
        end else begin
            ic_mode = M_IDLE;
        end
    end

    // closing kind of the pending token
    always_comb begin
        ck_has  = 1'b1;
        ck_kind = KIND_IDENT;
        unique case (r_mode)
            M_MINUS:           ck_kind = KIND_MINUS;
            M_SLASH:           ck_kind = KIND_SLASH;
            M_GT:              ck_kind = KIND_GT;
            M_LT:              ck_kind = KIND_LT;
            M_SEMI1, M_SEMI2:  ck_kind = KIND_SEMI;
            M_WORD: begin
                for (int i = 0; i < KW_COUNT; i++) begin
                    if (r_alive[i] && (KW_LEN[i] == r_len)) begin
                        ck_kind = KIND_KW_BASE + 6'(i);
                    end
                end
            end
            M_HATT:            ck_kind = KIND_HAT_NAME;
            M_QUEST:           ck_kind = KIND_QUES_NAME;
            M_NUMBER:          ck_kind = r_dot ? KIND_REAL : KIND_INTEGER;
            M_STRING:          ck_kind = KIND_STRING;
            M_COMMENT:         ck_kind = KIND_COMMENT;
            default:           ck_has  = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        n_mode  = r_mode;
        n_alive = r_alive;
        n_len   = r_len;
        n_dot   = r_dot;
        if (i_eoi) begin
            n_mode  = M_IDLE;
            n_alive = KW_ALL;
            n_len   = 3'd0;
            n_dot   = 1'b0;
        end else begin
            unique case (r_mode)
                M_MINUS, M_SLASH, M_GT, M_LT: begin
                    n_mode  = ic_mode;
                    n_alive = ic_alive;
                    n_len   = ic_len;
                    n_dot   = 1'b0;
                    if ((r_mode == M_MINUS && i_char == CH_GT) ||
                        (r_mode != M_MINUS && i_char == CH_EQ)) begin
                        n_mode  = M_IDLE;
                        n_alive = KW_ALL;
                        n_len   = 3'd0;
                    end
                end
                M_SEMI1, M_SEMI2: begin
                    if (i_char == CH_SEMI) begin
                        n_mode = (r_mode == M_SEMI1) ? M_SEMI2 : M_COMMENT;
                    end else begin
                        n_mode  = ic_mode;
                        n_alive = ic_alive;
                        n_len   = ic_len;
                        n_dot   = 1'b0;
                    end
                end
                M_HATP, M_QUESP: begin
                    if (is_alnum) begin
                        n_mode = (r_mode == M_HATP) ? M_HATT : M_QUEST;
                    end else begin
                        n_mode  = ic_mode;
                        n_alive = ic_alive;
                        n_len   = ic_len;
                        n_dot   = 1'b0;
                    end
                end
                M_WORD, M_HATT, M_QUEST: begin
                    if (is_word) begin
                        if (r_mode == M_WORD) begin
                            n_alive = w_next_alive;
                            n_len   = (r_len == 3'd7) ? 3'd7 : r_len + 3'd1;
                        end
                    end else begin
                        n_mode  = ic_mode;
                        n_alive = ic_alive;
                        n_len   = ic_len;
                        n_dot   = 1'b0;
                    end
                end
                M_NUMBER: begin
                    if (is_digit) begin
                        n_mode = M_NUMBER;
                    end else if (i_char == CH_DOT && !r_dot) begin
                        n_dot = 1'b1;
                    end else begin
                        n_mode  = ic_mode;
                        n_alive = ic_alive;
                        n_len   = ic_len;
                        n_dot   = 1'b0;
                    end
                end
                M_STRING, M_COMMENT: begin
                    if (i_char == CH_NEWLINE ||
                        (r_mode == M_STRING && i_char == CH_QUOTE)) begin
                        n_mode  = M_IDLE;
                        n_alive = KW_ALL;
                        n_len   = 3'd0;
                        n_dot   = 1'b0;
                    end
                end
                default: begin
                    n_mode  = ic_mode;
                    n_alive = ic_alive;
                    n_len   = ic_len;
                    n_dot   = 1'b0;
                end
            endcase
        end
    end

    // results
    always_comb begin
        logic close_then_idle;
        logic idle_only;
        close_then_idle = 1'b0;
        idle_only       = 1'b0;
        o_res.cnt = 2'd0;
        o_res.r0  = mk_kind(KIND_MINUS_GT);
        o_res.r1  = mk_kind(KIND_MINUS_GT);
        if (i_eoi) begin
            o_res.cnt = {1'b0, ck_has};
            o_res.r0  = mk_kind(ck_kind);
        end else begin
            unique case (r_mode)
                M_IDLE: idle_only = 1'b1;
                M_MINUS: begin
                    if (i_char == CH_GT) begin
                        o_res.cnt = 2'd1;
                        o_res.r0  = mk_kind(KIND_MINUS_GT);
                    end else begin
                        close_then_idle = 1'b1;
                    end
                end
                M_SLASH, M_GT, M_LT: begin
                    if (i_char == CH_EQ) begin
                        o_res.cnt = 2'd1;
                        o_res.r0  = mk_kind(ck_kind - 6'd1);
                    end else begin
                        close_then_idle = 1'b1;
                    end
                end
                M_SEMI1, M_SEMI2: begin
                    if (i_char != CH_SEMI) begin
                        close_then_idle = 1'b1;
                    end
                end
                M_HATP, M_QUESP: begin
                    if (is_alnum) begin
                        o_res.cnt = 2'd1;
                        o_res.r0  = mk_text(i_char);
                    end else begin
                        idle_only = 1'b1;
                    end
                end
                M_WORD, M_HATT, M_QUEST: begin
                    if (is_word) begin
                        o_res.cnt = 2'd1;
                        o_res.r0  = mk_text(i_char);
                    end else begin
                        close_then_idle = 1'b1;
                    end
                end
                M_NUMBER: begin
                    if (is_digit || (i_char == CH_DOT && !r_dot)) begin
                        o_res.cnt = 2'd1;
                        o_res.r0  = mk_text(i_char);
                    end else begin
                        close_then_idle = 1'b1;
                    end
                end
                M_STRING, M_COMMENT: begin
                    if (i_char == CH_NEWLINE ||
                        (r_mode == M_STRING && i_char == CH_QUOTE)) begin
                        o_res.cnt = 2'd1;
                        o_res.r0  = mk_kind(ck_kind);
                    end else begin
                        o_res.cnt = 2'd1;
                        o_res.r0  = mk_text(i_char);
                    end
                end
                default: idle_only = 1'b1;
            endcase
            if (close_then_idle && ck_has) begin
                o_res.r0  = mk_kind(ck_kind);
                o_res.r1  = ic_res;
                o_res.cnt = ic_emit ? 2'd2 : 2'd1;
            end else if (close_then_idle || idle_only) begin
                o_res.r0  = ic_res;
                o_res.cnt = {1'b0, ic_emit};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_alive <= KW_ALL;
            r_len   <= 3'd0;
            r_dot   <= 1'b0;
        end else if (i_fire) begin
            r_mode  <= n_mode;
            r_alive <= n_alive;
            r_len   <= n_len;
            r_dot   <= n_dot;
        end
    end

endmodule

[design/cst_out_buf.sv]
// two-entry result register that hands out one result per cycle while the output is not stalled
module cst_out_buf
    import cst_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_step_out  i_res,
    input  logic       i_out_stall,
    output logic       o_can_load,
    output logic       o_out_valid,
    output logic       o_is_text,
    output logic [7:0] o_text_char,
    output logic [5:0] o_token_kind,
    output logic       o_last_of_item
);

    logic [1:0] r_n;
    t_result    r_slot0, r_slot1;
    logic       r_last0;
    logic       out_acc;

    assign o_out_valid    = (r_n != 2'd0);
    assign out_acc        = o_out_valid && !i_out_stall;
    assign o_can_load     = (r_n == 2'd0) || ((r_n == 2'd1) && out_acc);
    assign o_is_text      = r_slot0.is_text;
    assign o_text_char    = r_slot0.text_char;
    assign o_token_kind   = r_slot0.token_kind;
    assign o_last_of_item = r_last0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= 2'd0;
        end else if (i_load) begin
            r_n <= i_res.cnt;
        end else if (out_acc) begin
            r_n <= (r_n == 2'd2) ? 2'd1 : 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_slot0 <= i_res.r0;
            r_last0 <= (i_res.cnt == 2'd1);
            r_slot1 <= i_res.r1;
        end else if (out_acc && r_n == 2'd2) begin
            r_slot0 <= r_slot1;
            r_last0 <= 1'b1;
        end
    end

endmodule

[design/char_stream_tokenizer.sv]
// top level of the character stream tokenizer
// Takes one source byte per request and streams tokens: each text character of an identifier,
// keyword, name, number, string or comment goes out as it arrives, followed by one closing
// result with the token kind. A byte passes through an input register, combinational decode
// against the tokenizer state, and a two-entry result register, from which its first result
// is presented on the outputs.
// The block takes one byte per cycle while each byte causes at most one result and the output
// is not stalled; a byte that causes two results (a pending token closed by the byte that starts
// the next) holds the input while the result register hands out its second entry. Bytes that
// cause no result still pass through the input register and the decode.
module char_stream_tokenizer
    import cst_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_char_byte,
    input  logic       i_end_of_input,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_is_text,
    output logic [7:0] o_text_char,
    output logic [5:0] o_token_kind,
    output logic       o_last_of_item
);

    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_eoi;
    logic       in_acc;
    logic       fire;
    logic       can_load;
    t_step_out  step_res;

    assign fire       = r_in_valid && can_load;
    assign o_in_stall = r_in_valid && !fire;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_char <= i_char_byte;
            r_in_eoi  <= i_end_of_input;
        end
    end

    cst_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_char  (r_in_char),
        .i_eoi   (r_in_eoi),
        .o_res   (step_res)
    );

    cst_out_buf u_out_buf (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (fire),
        .i_res          (step_res),
        .i_out_stall    (i_out_stall),
        .o_can_load     (can_load),
        .o_out_valid    (o_out_valid),
        .o_is_text      (o_is_text),
        .o_text_char    (o_text_char),
        .o_token_kind   (o_token_kind),
        .o_last_of_item (o_last_of_item)
    );

endmodule

[tb/sv/tb_char_stream_tokenizer.sv]
// testbench for char_stream_tokenizer: directed and random byte streams checked by a token predictor
module tb_char_stream_tokenizer
    import cst_pkg::*;
();

    class tok_scoreboard;
        typedef struct {
            t_result r;
            logic    last;
        } t_want;

        string               kw_words [KW_COUNT];
        t_want               want_q [$];
        t_mode               mode;
        logic [KW_COUNT-1:0] kw_live;
        logic [2:0]          word_len;
        logic                seen_dot;
        int                  errors;
        int                  result_cnt;

        function new();
            kw_words = '{
                "if", "for", "each", "repeat", "while", "times", "start", "fn",
                "bool", "int", "real", "string", "put", "else", "in", "list",
                "say", "pr", "prn", "true", "false", "input", "call"
            };
            errors     = 0;
            result_cnt = 0;
            go_idle();
        endfunction

        function int pending();
            return want_q.size();
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit is_alpha(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function bit is_alnum(logic [7:0] c);
            return is_alpha(c) || is_digit(c);
        endfunction

        function void go_idle();
            mode     = M_IDLE;
            kw_live  = KW_ALL;
            word_len = 3'd0;
            seen_dot = 1'b0;
        endfunction

        function void add_text(logic [7:0] c);
            t_want w;
            w.r.is_text    = 1'b1;
            w.r.text_char  = c;
            w.r.token_kind = 6'd0;
            w.last         = 1'b0;
            want_q.insert(want_q.size(), w);
        endfunction

        function void add_kind(logic [5:0] k);
            t_want w;
            w.r.is_text    = 1'b0;
            w.r.text_char  = 8'h00;
            w.r.token_kind = k;
            w.last         = 1'b0;
            want_q.insert(want_q.size(), w);
        endfunction

        function void word_char(logic [7:0] c);
            for (int i = 0; i < KW_COUNT; i++) begin
                if (word_len >= KW_POS || word_len >= kw_words[i].len()
                        || kw_words[i][word_len] != c) begin
                    kw_live[i] = 1'b0;
                end
            end
            if (word_len < 3'd7) begin
                word_len = word_len + 3'd1;
            end
            add_text(c);
        endfunction

        function void close_token();
            logic [5:0] k;
            logic       has;
            has = 1'b1;
            k   = KIND_IDENT;
            case (mode)
                M_MINUS: k = KIND_MINUS;
                M_SLASH: k = KIND_SLASH;
                M_GT:    k = KIND_GT;
                M_LT:    k = KIND_LT;
                M_SEMI1, M_SEMI2: k = KIND_SEMI;
                M_WORD: begin
                    for (int i = 0; i < KW_COUNT; i++) begin
                        if (kw_live[i] && kw_words[i].len() == word_len) begin
                            k = KIND_KW_BASE + 6'(i);
                        end
                    end
                end
                M_HATT:    k = KIND_HAT_NAME;
                M_QUEST:   k = KIND_QUES_NAME;
                M_NUMBER:  k = seen_dot ? KIND_REAL : KIND_INTEGER;
                M_STRING:  k = KIND_STRING;
                M_COMMENT: k = KIND_COMMENT;
                default:   has = 1'b0;
            endcase
            if (has) begin
                add_kind(k);
            end
            go_idle();
        endfunction

        function void start_char(logic [7:0] c);
            case (c)
                CH_MINUS:    mode = M_MINUS;
                CH_SLASH:    mode = M_SLASH;
                CH_GT:       mode = M_GT;
                CH_LT:       mode = M_LT;
                CH_PLUS:     add_kind(KIND_PLUS);
                CH_STAR:     add_kind(KIND_STAR);
                CH_EQ:       add_kind(KIND_EQ);
                CH_LBRACE:   add_kind(KIND_LBRACE);
                CH_RBRACE:   add_kind(KIND_RBRACE);
                CH_LBRACKET: add_kind(KIND_LBRACKET);
                CH_RBRACKET: add_kind(KIND_RBRACKET);
                CH_LPAREN:   add_kind(KIND_LPAREN);
                CH_RPAREN:   add_kind(KIND_RPAREN);
                CH_COLON:    add_kind(KIND_COLON);
                CH_HAT:      mode = M_HATP;
                CH_QUES:     mode = M_QUESP;
                CH_SEMI:     mode = M_SEMI1;
                CH_QUOTE:    mode = M_STRING;
                default: begin
                    if (is_alpha(c) || c == CH_UNDER) begin
                        mode = M_WORD;
                        word_char(c);
                    end else if (is_digit(c)) begin
                        mode = M_NUMBER;
                        add_text(c);
                    end
                end
            endcase
        endfunction

        function void pair_or_single(logic [7:0] c, logic [7:0] second,
                                     logic [5:0] pair_kind);
            if (c == second) begin
                add_kind(pair_kind);
                go_idle();
            end else begin
                close_token();
                start_char(c);
            end
        endfunction

        function void note_request(logic [7:0] c, logic eoi);
            int n0;
            n0 = want_q.size();
            if (eoi) begin
                close_token();
            end else begin
                case (mode)
                    M_IDLE:  start_char(c);
                    M_MINUS: pair_or_single(c, CH_GT, KIND_MINUS_GT);
                    M_SLASH: pair_or_single(c, CH_EQ, KIND_SLASH_EQ);
                    M_GT:    pair_or_single(c, CH_EQ, KIND_GT_EQ);
                    M_LT:    pair_or_single(c, CH_EQ, KIND_LT_EQ);
                    M_SEMI1, M_SEMI2: begin
                        if (c == CH_SEMI) begin
                            mode = (mode == M_SEMI1) ? M_SEMI2 : M_COMMENT;
                        end else begin
                            close_token();
                            start_char(c);
                        end
                    end
                    M_HATP, M_QUESP: begin
                        if (is_alnum(c)) begin
                            mode = (mode == M_HATP) ? M_HATT : M_QUEST;
                            add_text(c);
                        end else begin
                            go_idle();
                            start_char(c);
                        end
                    end
                    M_WORD, M_HATT, M_QUEST: begin
                        if (is_alnum(c) || c == CH_UNDER) begin
                            if (mode == M_WORD) begin
                                word_char(c);
                            end else begin
                                add_text(c);
                            end
                        end else begin
                            close_token();
                            start_char(c);
                        end
                    end
                    M_NUMBER: begin
                        if (is_digit(c)) begin
                            add_text(c);
                        end else if (c == CH_DOT && !seen_dot) begin
                            seen_dot = 1'b1;
                            add_text(c);
                        end else begin
                            close_token();
                            start_char(c);
                        end
                    end
                    M_STRING: begin
                        if (c == CH_QUOTE || c == CH_NEWLINE) begin
                            close_token();
                        end else begin
                            add_text(c);
                        end
                    end
                    M_COMMENT: begin
                        if (c == CH_NEWLINE) begin
                            close_token();
                        end else begin
                            add_text(c);
                        end
                    end
                    default: begin
                        go_idle();
                        start_char(c);
                    end
                endcase
            end
            if (want_q.size() > n0) begin
                want_q[want_q.size() - 1].last = 1'b1;
            end
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(logic t, logic [7:0] ch, logic [5:0] k, logic last);
            t_want w;
            result_cnt++;
            if (want_q.size() == 0) begin
                report($sformatf("result %0d arrived with none pending", result_cnt));
            end else begin
                w = want_q.pop_front();
                if (t !== w.r.is_text)
                    report($sformatf("result %0d is_text %b, want %b", result_cnt, t,
                                     w.r.is_text));
                if (ch !== w.r.text_char)
                    report($sformatf("result %0d text_char %h, want %h", result_cnt, ch,
                                     w.r.text_char));
                if (k !== w.r.token_kind)
                    report($sformatf("result %0d token_kind %0d, want %0d", result_cnt, k,
                                     w.r.token_kind));
                if (last !== w.last)
                    report($sformatf("result %0d last_of_item %b, want %b", result_cnt,
                                     last, w.last));
            end
        endtask
    endclass

    localparam int RANDOM_ITEMS  = 1650;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 150;
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        logic [7:0] c;
        logic       eoi;
    } t_src;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [7:0] i_char_byte;
    logic       i_end_of_input;
    logic       o_out_valid;
    logic       i_out_stall;
    logic       o_is_text;
    logic [7:0] o_text_char;
    logic [5:0] o_token_kind;
    logic       o_last_of_item;

    tok_scoreboard sb;
    t_src          src_q [$];
    bit            gaps_on   = 1'b1;
    bit            hold_req  = 1'b0;
    int            cycle_cnt = 0;

    logic [7:0] op_chars [14] = '{
        CH_MINUS, CH_SLASH, CH_GT, CH_LT, CH_PLUS, CH_STAR, CH_EQ,
        CH_LBRACE, CH_RBRACE, CH_LBRACKET, CH_RBRACKET, CH_LPAREN, CH_RPAREN, CH_COLON
    };

    char_stream_tokenizer DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_char_byte    (i_char_byte),
        .i_end_of_input (i_end_of_input),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_is_text      (o_is_text),
        .o_text_char    (o_text_char),
        .o_token_kind   (o_token_kind),
        .o_last_of_item (o_last_of_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("[char_stream_tokenizer] ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_is_text, o_text_char, o_token_kind, o_last_of_item);
        end
    end

    // result side: random stalls plus one long hold-off on request
    initial begin
        int k;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                for (k = 0; k < HOLD_CYCLES; k++) begin
                    i_out_stall <= 1'b1;
                    @(negedge i_clk);
                end
                hold_req = 1'b0;
            end
            i_out_stall <= gaps_on && ($urandom_range(0, 99) < 13);
        end
    end

    task automatic send_req(input logic [7:0] c, input logic eoi);
        while (gaps_on && $urandom_range(0, 99) < 13) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_char_byte    <= c;
        i_end_of_input <= eoi;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_request(c, eoi);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic void add_src(input logic [7:0] c, input logic eoi);
        t_src s;
        s.c   = c;
        s.eoi = eoi;
        src_q.insert(src_q.size(), s);
    endfunction

    function automatic logic [7:0] pick_name_char(input bit with_under);
        int r;
        r = $urandom_range(0, with_under ? 62 : 61);
        if (r < 26) return "a" + 8'(r);
        if (r < 52) return "A" + 8'(r - 26);
        if (r < 62) return "0" + 8'(r - 52);
        return CH_UNDER;
    endfunction

    function automatic logic [7:0] pick_digit();
        return "0" + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] pick_body_byte();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        if (c == CH_QUOTE || c == CH_NEWLINE) c = "x";
        return c;
    endfunction

    // one well-formed token most of the time, otherwise separators, noise or end of input
    function automatic void make_fragment();
        int         pick;
        int         n;
        int         i;
        logic [7:0] c;
        string      w;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            w = sb.kw_words[$urandom_range(0, KW_COUNT - 1)];
            for (i = 0; i < w.len(); i++) add_src(w[i], 1'b0);
            if ($urandom_range(0, 3) == 0) add_src(pick_name_char(1'b1), 1'b0);
        end else if (pick < 28) begin
            add_src(($urandom_range(0, 5) == 0) ? CH_UNDER : "a" + 8'($urandom_range(0, 25)),
                    1'b0);
            n = $urandom_range(0, 9);
            for (i = 0; i < n; i++) add_src(pick_name_char(1'b1), 1'b0);
        end else if (pick < 40) begin
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++) add_src(pick_digit(), 1'b0);
            if ($urandom_range(0, 1) == 0) begin
                add_src(CH_DOT, 1'b0);
                n = $urandom_range(0, 3);
                for (i = 0; i < n; i++) add_src(pick_digit(), 1'b0);
                if ($urandom_range(0, 3) == 0) begin
                    add_src(CH_DOT, 1'b0);
                    add_src(pick_digit(), 1'b0);
                end
            end
        end else if (pick < 48) begin
            add_src(CH_QUOTE, 1'b0);
            n = $urandom_range(0, 8);
            for (i = 0; i < n; i++) add_src(pick_body_byte(), 1'b0);
            add_src(($urandom_range(0, 3) == 0) ? CH_NEWLINE : CH_QUOTE, 1'b0);
        end else if (pick < 54) begin
            for (i = 0; i < 3; i++) add_src(CH_SEMI, 1'b0);
            n = $urandom_range(0, 8);
            for (i = 0; i < n; i++) add_src(pick_body_byte(), 1'b0);
            if ($urandom_range(0, 9) != 0) add_src(CH_NEWLINE, 1'b0);
        end else if (pick < 60) begin
            n = $urandom_range(1, 2);
            for (i = 0; i < n; i++) add_src(CH_SEMI, 1'b0);
        end else if (pick < 76) begin
            c = op_chars[$urandom_range(0, 13)];
            add_src(c, 1'b0);
            if ($urandom_range(0, 4) < 2) add_src((c == CH_MINUS) ? CH_GT : CH_EQ, 1'b0);
        end else if (pick < 84) begin
            add_src(($urandom_range(0, 1) == 0) ? CH_HAT : CH_QUES, 1'b0);
            if ($urandom_range(0, 9) < 7) begin
                add_src(pick_name_char(1'b0), 1'b0);
                n = $urandom_range(0, 4);
                for (i = 0; i < n; i++) add_src(pick_name_char(1'b1), 1'b0);
            end
        end else if (pick < 92) begin
            add_src(($urandom_range(0, 1) == 0) ? " " : CH_NEWLINE, 1'b0);
        end else if (pick < 98) begin
            add_src(8'($urandom_range(0, 255)), 1'b0);
        end else begin
            add_src(8'($urandom_range(0, 255)), 1'b1);
        end
    endfunction

    initial begin
        int    n;
        t_src  s;
        string intro;
        sb             = new();
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_char_byte    = 8'h00;
        i_end_of_input = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        intro = "^?a->b/=<;;c;;;x\n1.2.3\"s\npr";
        for (n = 0; n < intro.len(); n++) send_req(intro[n], 1'b0);
        send_req(8'hFF, 1'b0);
        send_req(8'h00, 1'b0);
        send_req(CH_HAT, 1'b0);
        send_req(8'hFF, 1'b1);
        drain_results();

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 300) hold_req = 1'b1;
            if (n == 700) gaps_on = 1'b0;
            if (n == 1000) gaps_on = 1'b1;
            if (n == 1300) drain_results();
            if (src_q.size() == 0) make_fragment();
            s = src_q.pop_front();
            send_req(s.c, s.eoi);
        end
        send_req(8'h00, 1'b1);
        drain_results();

        if (sb.errors == 0) begin
            $display("[char_stream_tokenizer] OK");
        end else begin
            $display("[char_stream_tokenizer] ERROR");
        end
        $finish;
    end
endmodule
